@@ design/circular_deque_buffer_unit_defines.svh @@
// Assertion macros shared by the checker of the circular deque buffer unit.
// No dependencies; included by files that carry assertions.
`ifndef CIRCULAR_DEQUE_BUFFER_UNIT_DEFINES_SVH
`define CIRCULAR_DEQUE_BUFFER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define CDB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cdb check failed");

// Next-cycle implication, disabled during reset.
`define CDB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cdb check failed");

`endif

@@ design/cdb_pkg.sv @@
// Shared types and constants for the circular deque buffer unit.
// No dependencies.
`default_nettype none
package cdb_pkg;

    localparam int CDB_CAPACITY = 16;
    localparam int DATA_W       = 32;

    // Operation codes
    localparam logic [1:0] FN_PUSH_BACK  = 2'd0;
    localparam logic [1:0] FN_PUSH_FRONT = 2'd1;
    localparam logic [1:0] FN_POP_FRONT  = 2'd2;
    localparam logic [1:0] FN_POP_BACK   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic exec;   // run the accepted operation this cycle
        logic show;   // result transfer cycle
    } cdb_cmd_t;

endpackage
`default_nettype wire

@@ design/circular_deque_buffer_unit.sv @@
// Circular deque buffer unit: push/pop at either end of a CAPACITY-entry ring.
// The result strobe (done) comes in the cycle right after the start transfer.
// A new operation is not accepted while a result is pending: busy is high in
// the result cycle, which the entry memory's registered read port sets.
// Results cannot be stalled: done marks each result for exactly one cycle.
// Reset (rst_n low, async): deque empty, head and tail at zero, no result pending.
// Depends on cdb_pkg, cdb_ctrl, cdb_dpath.
`default_nettype none
module circular_deque_buffer_unit #(
    parameter int CAPACITY = cdb_pkg::CDB_CAPACITY
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // command side: a transfer happens when start is high and busy is low
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        func,
    input  wire logic signed [cdb_pkg::DATA_W-1:0] push_value,
    // result side: one transfer per command, strobed by done
    output logic                                   done,
    output logic [1:0]                             status,
    output logic                                   pop_valid,
    output logic signed [cdb_pkg::DATA_W-1:0]      popped_value
);

    // Command bundle from the sequencer: exec in the transfer cycle,
    // show in the result cycle.
    cdb_pkg::cdb_cmd_t cmd;

    // Sequencer: idle -> respond -> idle. The datapath executes the whole
    // operation (index update, memory write or read) at the start transfer.
    cdb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // Datapath: head/tail indices, empty flag, entry memory with one write
    // and one registered read port, and the result registers. A pop reads
    // the memory at the transfer edge; the data is presented on done.
    cdb_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .func         (func),
        .push_value   (push_value),
        .status       (status),
        .pop_valid    (pop_valid),
        .popped_value (popped_value)
    );

endmodule
`default_nettype wire

@@ design/cdb_ctrl.sv @@
// Controller of the circular deque buffer: two-state sequencer.
// Depends on cdb_pkg.
`default_nettype none
module cdb_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    output logic                  done,
    output cdb_pkg::cdb_cmd_t     cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RESP = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign done     = (state_reg == S_RESP);
    assign cmd.exec = start && (state_reg == S_IDLE);
    assign cmd.show = (state_reg == S_RESP);

endmodule
`default_nettype wire

@@ design/cdb_dpath.sv @@
// Datapath of the circular deque buffer: indices, entry memory, result registers.
// Depends on cdb_pkg.
`default_nettype none
module cdb_dpath #(
    parameter int CAPACITY = cdb_pkg::CDB_CAPACITY
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire cdb_pkg::cdb_cmd_t                 cmd,
    input  wire logic [1:0]                        func,
    input  wire logic signed [cdb_pkg::DATA_W-1:0] push_value,
    output logic [1:0]                             status,
    output logic                                   pop_valid,
    output logic signed [cdb_pkg::DATA_W-1:0]      popped_value
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);

    logic [cdb_pkg::DATA_W-1:0] mem [CAPACITY];
    logic [cdb_pkg::DATA_W-1:0] rd_data_reg;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic             empty_reg, empty_next;
    logic [1:0]       status_reg, status_next;
    logic             pop_valid_reg, pop_valid_next;

    logic             wr_en, rd_en;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    logic [IDX_W-1:0] tail_inc, tail_dec, head_inc, head_dec;
    logic             full;

    assign tail_inc = (tail_reg == IDX_LAST) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? IDX_LAST : tail_reg - 1'b1;
    assign head_inc = (head_reg == IDX_LAST) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? IDX_LAST : head_reg - 1'b1;
    assign full     = !empty_reg && (tail_inc == head_reg);

    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        empty_next     = empty_reg;
        status_next    = status_reg;
        pop_valid_next = pop_valid_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        rd_en          = 1'b0;
        rd_addr        = head_reg;
        if (cmd.exec)
        begin
            status_next    = cdb_pkg::ST_OK;
            pop_valid_next = 1'b0;
            if (func == cdb_pkg::FN_PUSH_BACK || func == cdb_pkg::FN_PUSH_FRONT)
            begin
                if (full)
                begin
                    status_next = cdb_pkg::ST_OVERFLOW;
                end
                else if (empty_reg)
                begin
                    // first element always lands in slot zero
                    head_next  = '0;
                    tail_next  = '0;
                    empty_next = 1'b0;
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                end
                else if (func == cdb_pkg::FN_PUSH_BACK)
                begin
                    tail_next = tail_inc;
                    wr_en     = 1'b1;
                    wr_addr   = tail_inc;
                end
                else
                begin
                    head_next = head_dec;
                    wr_en     = 1'b1;
                    wr_addr   = head_dec;
                end
            end
            else
            begin
                if (empty_reg)
                begin
                    status_next = cdb_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    pop_valid_next = 1'b1;
                    rd_en          = 1'b1;
                    rd_addr        = (func == cdb_pkg::FN_POP_FRONT) ? head_reg : tail_reg;
                    if (head_reg == tail_reg)
                    begin
                        // last element leaves: back to the reset picture
                        empty_next = 1'b1;
                        head_next  = '0;
                        tail_next  = '0;
                    end
                    else if (func == cdb_pkg::FN_POP_FRONT)
                    begin
                        head_next = head_inc;
                    end
                    else
                    begin
                        tail_next = tail_dec;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            empty_reg     <= 1'b1;
            status_reg    <= cdb_pkg::ST_OK;
            pop_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            empty_reg     <= empty_next;
            status_reg    <= status_next;
            pop_valid_reg <= pop_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= push_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign status       = status_reg;
    assign pop_valid    = pop_valid_reg && cmd.show;
    assign popped_value = (pop_valid_reg && cmd.show) ? $signed(rd_data_reg) : '0;

endmodule
`default_nettype wire

@@ design/cdb_checker.sv @@
// Port-level checker for the circular deque buffer unit, bound to the top level.
// Depends on cdb_pkg and circular_deque_buffer_unit_defines.svh.
`default_nettype none
`include "circular_deque_buffer_unit_defines.svh"
module cdb_port_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              start,
    input wire logic                              busy,
    input wire logic                              done,
    input wire logic [1:0]                        status,
    input wire logic                              pop_valid,
    input wire logic signed [cdb_pkg::DATA_W-1:0] popped_value
);

    // every command transfer yields a result in the next cycle
    `CDB_ASSERT_NEXT(a_start_done, clk, rst_n, start && !busy, done)
    // no result without a command transfer just before it
    `CDB_ASSERT_NOW(a_done_cause, clk, rst_n, done, $past(start && !busy))
    // a popped value is only nonzero on a successful pop
    `CDB_ASSERT_NOW(a_pop_zero, clk, rst_n, done && !pop_valid, popped_value == '0)
    // a successful pop reports ok
    `CDB_ASSERT_NOW(a_pop_ok, clk, rst_n, done && pop_valid, status == cdb_pkg::ST_OK)

endmodule

bind circular_deque_buffer_unit cdb_port_checker u_cdb_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .pop_valid    (pop_valid),
    .popped_value (popped_value)
);
`default_nettype wire
